### design/lfts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfts_pkg
// Shared types and constants for the linear flow Taylor step block.
// ----------------------------------------------------------------------------
package lfts_pkg;

    typedef logic [3:0][31:0] mat_t;    // row-major: index 2*row + col

    typedef struct packed {
        mat_t        a;
        logic [31:0] b0;
        logic [31:0] b1;
        logic [31:0] u;
        logic [31:0] v;
    } item_t;

    typedef struct packed {
        logic [3:0][31:0] wh;   // weights of H, lowest power first
        logic [2:0][31:0] we;   // weights of e, lowest power first
    } wgt_t;

    localparam int           ADDR_BITS  = 3;
    localparam logic         REG_STEP   = 1'b0;
    localparam logic [30:0]  STEP_RESET = 31'd16777;

endpackage

### design/lfts_wgt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfts_wgt
// Taylor weight unit: derives dt powers and the divided weights from the
// step size with one shared multiplier.
// ----------------------------------------------------------------------------
module lfts_wgt
    import lfts_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] step_size,
    output wgt_t        wgt,
    output logic        busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P2   = 3'd1;
    localparam logic [2:0] ST_P3   = 3'd2;
    localparam logic [2:0] ST_P4   = 3'd3;
    localparam logic [2:0] ST_D0   = 3'd4;
    localparam logic [2:0] ST_D1   = 3'd5;
    localparam logic [2:0] ST_D2   = 3'd6;
    localparam logic [2:0] ST_D3   = 3'd7;

    localparam logic [65:0] HALF  = 66'd1 << (FRAC_BITS - 1);
    localparam logic [65:0] FXMAX = 66'd2147483647;
    localparam logic [32:0] RECIP3 = 33'h0AAAAAAAB;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [30:0] p2_reg, p3_reg, p4_reg;
    logic [30:0] wh2_reg, wh3_reg, we1_reg, we2_reg;
    logic [32:0] op_a, op_b;
    logic [65:0] prod;
    logic [65:0] rnd;
    logic [30:0] fx;
    logic [32:0] q3;

    always_comb
    begin
        op_a = {2'b00, step_size};
        op_b = {2'b00, step_size};
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_P2:
            begin
                state_next = ST_P3;
            end
            ST_P3:
            begin
                op_a = {2'b00, p2_reg};
                state_next = ST_P4;
            end
            ST_P4:
            begin
                op_a = {2'b00, p3_reg};
                state_next = ST_D0;
            end
            ST_D0:
            begin
                op_a = {2'b00, p3_reg} + 33'd3;
                op_b = RECIP3;
                state_next = ST_D1;
            end
            ST_D1:
            begin
                op_a = {2'b00, p4_reg} + 33'd12;
                op_b = RECIP3;
                state_next = ST_D2;
            end
            ST_D2:
            begin
                op_a = {2'b00, p2_reg} + 33'd3;
                op_b = RECIP3;
                state_next = ST_D3;
            end
            ST_D3:
            begin
                op_a = {2'b00, p3_reg} + 33'd12;
                op_b = RECIP3;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (start)
            state_next = ST_P2;
    end

    assign prod = 66'(op_a) * 66'(op_b);
    assign rnd  = (prod + HALF) >> FRAC_BITS;
    assign fx   = (rnd > FXMAX) ? 31'h7FFFFFFF : rnd[30:0];
    // floor(x / 3) for any 32-bit x
    assign q3   = 33'(prod >> 33);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_P2;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_P2: p2_reg <= fx;
            ST_P3: p3_reg <= fx;
            ST_P4: p4_reg <= fx;
            ST_D0: wh2_reg <= 31'(q3 >> 1);
            ST_D1: wh3_reg <= 31'(q3 >> 3);
            ST_D2: we1_reg <= 31'(q3 >> 1);
            ST_D3: we2_reg <= 31'(q3 >> 3);
            default: ;
        endcase
    end

    always_comb
    begin
        wgt.wh[0] = {1'b0, step_size};
        wgt.wh[1] = 32'(({1'b0, p2_reg} + 32'd1) >> 1);
        wgt.wh[2] = {1'b0, wh2_reg};
        wgt.wh[3] = {1'b0, wh3_reg};
        wgt.we[0] = 32'(({1'b0, step_size} + 32'd1) >> 1);
        wgt.we[1] = {1'b0, we1_reg};
        wgt.we[2] = {1'b0, we2_reg};
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### design/linear_flow_taylor_step_2x2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_flow_taylor_step_2x2
// Advances one point of p' = A p + b by a fourth-order Taylor step of the
// matrix exponential, in saturating signed fixed point.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | role
//  ---------+------------------------------------------+-----------------------
//  in       | in_valid/in_ready, cell_tag, coef_*,     | one point per beat
//           | bias_*, pos_*                            |
//  out      | out_valid/out_ready, out_tag, next_*     | one result per beat
//  apb      | psel penable pwrite paddr pwdata prdata  | step_size at 0x0
//
//  One item per cycle while neither the weight unit nor the output stalls;
//  items pass the Horner stages (two register stages per matrix product)
//  and the final apply stages. After reset and after each step_size write
//  the weight unit runs with its one multiplier; in_ready stays low meanwhile.
//  A stall at the output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module linear_flow_taylor_step_2x2
    import lfts_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int TAG_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TAG_BITS-1:0]  cell_tag,
    input  logic signed [31:0]   coef_00,
    input  logic signed [31:0]   coef_01,
    input  logic signed [31:0]   coef_10,
    input  logic signed [31:0]   coef_11,
    input  logic signed [31:0]   bias_0,
    input  logic signed [31:0]   bias_1,
    input  logic signed [31:0]   pos_u,
    input  logic signed [31:0]   pos_v,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TAG_BITS-1:0]  out_tag,
    output logic signed [31:0]   next_u,
    output logic signed [31:0]   next_v
);

    localparam int PW     = 64 - FRAC_BITS;    // rounded product width
    localparam int SW     = PW + 2;
    localparam int NSTAGE = 13;
    localparam int LAST   = NSTAGE - 1;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SMIN = SW'(-64'sd2147483648);
    localparam logic signed [SW-1:0] ONE  = SW'(64'sd1 <<< FRAC_BITS);

    function automatic logic signed [PW-1:0] rprod(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        logic signed [63:0] t;
        t = 64'(x) * 64'(y) + HALF;
        return PW'(t >>> FRAC_BITS);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [SW-1:0] x);
        logic [31:0] r;
        if (x > SMAX)
            r = 32'h7FFFFFFF;
        else if (x < SMIN)
            r = 32'h80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [30:0] step_reg;
    logic        cfg_wr;
    logic        wbusy;
    wgt_t        wgt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STEP);
    assign prdata = (paddr[2] == REG_STEP) ? {1'b0, step_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_RESET;
        else if (cfg_wr)
            step_reg <= pwdata[30:0];
    end

    lfts_wgt #(.FRAC_BITS(FRAC_BITS)) u_wgt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_wr),
        .step_size (step_reg),
        .wgt       (wgt),
        .busy      (wbusy)
    );

    // ---------------- pipeline ----------------
    logic                  adv;
    logic [NSTAGE-1:0]     v_reg;
    item_t                 it_reg  [NSTAGE];
    logic [TAG_BITS-1:0]   tag_reg [NSTAGE];
    item_t                 in_item;

    mat_t                  mh_reg [4];
    mat_t                  mh_next [4];
    mat_t                  mt_reg [1:3];
    mat_t                  mt_next [1:3];
    logic signed [PW-1:0]  ph_reg [4][8];
    logic signed [PW-1:0]  ph_next [4][8];
    logic signed [PW-1:0]  pt_reg [1:3][8];
    logic signed [PW-1:0]  pt_next [1:3][8];

    mat_t                  h_reg, t_reg, h_next, t_next;
    logic signed [PW-1:0]  hp_reg [4];
    logic signed [PW-1:0]  tp_reg [4];
    logic signed [PW:0]    hs_reg [2];
    logic [31:0]           w_reg [2];
    logic signed [PW:0]    hs2_reg [2];
    logic [31:0]           e_reg [2];
    logic [31:0]           nu_reg, nv_reg;

    // hold everything while the output beat waits
    assign adv      = !v_reg[LAST] || out_ready;
    assign in_ready = adv && !wbusy;

    assign in_item.a  = {coef_11, coef_10, coef_01, coef_00};
    assign in_item.b0 = bias_0;
    assign in_item.b1 = bias_1;
    assign in_item.u  = pos_u;
    assign in_item.v  = pos_v;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mh_next[0][r] = (r == 0 || r == 3) ? wgt.wh[3] : 32'd0;
            mt_next[1][r] = (r == 0 || r == 3) ? wgt.we[2] : 32'd0;
        end
        for (int j = 1; j < 4; j++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                mh_next[j][r] = sat32(SW'(ph_reg[j-1][2*r]) + SW'(ph_reg[j-1][2*r+1]));
                if (r == 0 || r == 3)
                    mh_next[j][r] = sat32(SW'($signed(mh_next[j][r]))
                                          + SW'($signed(wgt.wh[3-j])));
            end
        end
        for (int j = 2; j < 4; j++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                mt_next[j][r] = sat32(SW'(pt_reg[j-1][2*r]) + SW'(pt_reg[j-1][2*r+1]));
                if (r == 0 || r == 3)
                    mt_next[j][r] = sat32(SW'($signed(mt_next[j][r]))
                                          + SW'($signed(wgt.we[3-j])));
            end
        end
        // products of M x A: entry (i,c) uses m[i][0]*a[0][c] and m[i][1]*a[1][c]
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        ph_next[j][2*(2*i+c)+k] = rprod($signed(mh_reg[j][2*i+k]),
                                                        $signed(it_reg[2*j].a[2*k+c]));
                    end
                end
            end
        end
        for (int j = 1; j < 4; j++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        pt_next[j][2*(2*i+c)+k] = rprod($signed(mt_reg[j][2*i+k]),
                                                        $signed(it_reg[2*j].a[2*k+c]));
                    end
                end
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            h_next[r] = sat32(SW'(ph_reg[3][2*r]) + SW'(ph_reg[3][2*r+1]));
            t_next[r] = sat32(SW'(pt_reg[3][2*r]) + SW'(pt_reg[3][2*r+1]));
            if (r == 0 || r == 3)
            begin
                h_next[r] = sat32(SW'($signed(h_next[r])) + ONE);
                t_next[r] = sat32(SW'($signed(t_next[r])) + ONE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NSTAGE-2:0], in_valid && !wbusy};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_reg[0]  <= in_item;
            tag_reg[0] <= cell_tag;
            for (int s = 1; s < NSTAGE; s++)
            begin
                it_reg[s]  <= it_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
            // Horner stages: even index forms M, odd index multiplies by A
            for (int j = 0; j < 4; j++)
            begin
                mh_reg[j] <= mh_next[j];
                ph_reg[j] <= ph_next[j];
            end
            for (int j = 1; j < 4; j++)
            begin
                mt_reg[j] <= mt_next[j];
                pt_reg[j] <= pt_next[j];
            end
            // stage 8: close H and T
            h_reg <= h_next;
            t_reg <= t_next;
            // stage 9: apply to p and b
            hp_reg[0] <= rprod($signed(h_reg[0]), $signed(it_reg[8].u));
            hp_reg[1] <= rprod($signed(h_reg[1]), $signed(it_reg[8].v));
            hp_reg[2] <= rprod($signed(h_reg[2]), $signed(it_reg[8].u));
            hp_reg[3] <= rprod($signed(h_reg[3]), $signed(it_reg[8].v));
            tp_reg[0] <= rprod($signed(t_reg[0]), $signed(it_reg[8].b0));
            tp_reg[1] <= rprod($signed(t_reg[1]), $signed(it_reg[8].b1));
            tp_reg[2] <= rprod($signed(t_reg[2]), $signed(it_reg[8].b0));
            tp_reg[3] <= rprod($signed(t_reg[3]), $signed(it_reg[8].b1));
            // stage 10
            for (int i = 0; i < 2; i++)
            begin
                hs_reg[i] <= (PW+1)'(hp_reg[2*i]) + (PW+1)'(hp_reg[2*i+1]);
                w_reg[i]  <= sat32(SW'(tp_reg[2*i]) + SW'(tp_reg[2*i+1]));
            end
            // stage 11: scale by dt
            for (int i = 0; i < 2; i++)
            begin
                hs2_reg[i] <= hs_reg[i];
                e_reg[i]   <= sat32(SW'(rprod($signed({1'b0, step_reg}),
                                                $signed(w_reg[i]))));
            end
            // stage 12: output
            nu_reg <= sat32(SW'(hs2_reg[0]) + SW'($signed(e_reg[0])));
            nv_reg <= sat32(SW'(hs2_reg[1]) + SW'($signed(e_reg[1])));
        end
    end

    assign out_valid = v_reg[LAST];
    assign out_tag   = tag_reg[LAST];
    assign next_u    = $signed(nu_reg);
    assign next_v    = $signed(nv_reg);

    // ---------------- assertions ----------------
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        wbusy |-> !in_ready)
        else $error("input taken while weights are being derived");

    a_write_starts_weights: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> wbusy)
        else $error("step_size write did not restart the weight unit");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(v_reg))
        else $error("pipeline moved during an output stall");

endmodule
